>>> hdl/hnm_pkg.sv
// shared constants, word types and state codes of the heightmap normal generator
package hnm_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int OUT_FRAC_BITS = 14;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WCNT_W = ADDR_W + 1;
    localparam int MAG_W  = 24;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ACC_W  = SUM_W + 2 * OUT_FRAC_BITS + 8;
    localparam int LO_W   = OUT_FRAC_BITS + 1;
    localparam int K_W    = $clog2(OUT_FRAC_BITS + 1);

    typedef enum logic [1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_SCALE   = 2'd2,
        CFG_SPACING = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_DRAIN  = 1'b1
    } req_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_SQ,
        ST_SUM,
        ST_NSTART,
        ST_NWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] height_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [10:0]        pixel_col;
        logic [15:0]        pixel_row;
        logic               frame_end;
    } out_word_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  msq;
    } norm_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] value;
    } norm_rsp_t;

endpackage

>>> hdl/hnm_ram.sv
// generic single write port, single read port ram with registered read data
module hnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/hnm_norm.sv
// bit-serial normalizer: round(mag * 2^frac / sqrt(sum)) by an add-only bit search
module hnm_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  hnm_pkg::norm_req_t  req,
    output hnm_pkg::norm_rsp_t  rsp
);

    localparam int F = hnm_pkg::OUT_FRAC_BITS;
    localparam int W = hnm_pkg::ACC_W;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [hnm_pkg::K_W-1:0]   k_reg, k_next;
    logic [hnm_pkg::LO_W-1:0]  lo_reg, lo_next;
    logic signed [W-1:0]       p_reg, p_next;
    logic signed [W-1:0]       a_reg, a_next;
    logic signed [W-1:0]       b_reg, b_next;
    logic signed [W-1:0]       m_reg, m_next;
    logic                      neg_reg, neg_next;
    logic                      zero_reg, zero_next;
    logic signed [W-1:0]       cand;
    logic signed [W-1:0]       sum_ext;
    logic signed [W-1:0]       lo_ext;

    assign cand    = p_reg + a_reg + b_reg;
    assign sum_ext = W'(req.sum);
    assign lo_ext  = W'(lo_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        lo_next   = lo_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            k_next    = hnm_pkg::K_W'(F);
            lo_next   = '0;
            p_next    = sum_ext;
            a_next    = -(sum_ext <<< (F + 2));
            b_next    = sum_ext <<< (2 * F + 2);
            m_next    = W'(req.msq) <<< (2 * F + 2);
            neg_next  = req.neg;
            zero_next = (req.msq == '0);
        end
        else if (busy_reg)
        begin
            if (cand <= m_reg)
            begin
                p_next        = cand;
                lo_next[k_reg] = 1'b1;
                a_next        = (a_reg >>> 1) + b_reg;
            end
            else
            begin
                a_next = a_reg >>> 1;
            end
            b_next = b_reg >>> 2;
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        lo_reg   <= lo_next;
        p_reg    <= p_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        m_reg    <= m_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (zero_reg)
        begin
            rsp.value = '0;
        end
        else if (neg_reg)
        begin
            rsp.value = 16'(-lo_ext);
        end
        else
        begin
            rsp.value = 16'(lo_ext);
        end
    end

endmodule

>>> hdl/heightmap_normal_generator.sv
// top level: line buffers in ram, raster counters, sequencer and normalizer
//
//  channel | direction | handshake          | word
//  in      | into      | in_valid/in_stall  | req_type, height_sample
//  out     | out of    | out_valid/out_stall| normal_x/y/z, pixel_col, pixel_row, frame_end
//  cfg     | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a word with a result passes through these steps in order: accept in idle, the two line buffer
// reads per ram and the write-back, products, squares and sum, the three normalizer
// bit searches, one per component, and the load of the output register
// a word with no result returns to idle after the write-back; an ignored word leaves the sequencer in idle.
// reset clears counters and control; line buffers are not cleared
// the finished word waits in the output register while the next word is taken in;
// a stalled full output register holds the sequencer in its last state
module heightmap_normal_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hnm_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output hnm_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = hnm_pkg::ADDR_W;
    localparam int WW = hnm_pkg::WCNT_W;

    hnm_pkg::state_t state_reg, state_next;

    logic [11:0] width_reg;
    logic [15:0] height_reg, scale_reg, spacing_reg;

    logic [AW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [AW-1:0] drain_reg, drain_next;

    logic [AW-1:0] pos_reg;
    logic [15:0]   erow_reg;
    logic          drain_item_reg, emit_reg, left_ok_reg, right_ok_reg, up_ok_reg, last_reg;
    logic [7:0]    sample_reg, ctr_reg, left_reg, right_reg, up_reg;
    logic [hnm_pkg::MAG_W-1:0] mag_reg [3];
    logic          neg_reg [3];
    logic [hnm_pkg::SQ_W-1:0]  sq_reg [3];
    logic [hnm_pkg::SUM_W-1:0] sum_reg;
    logic [1:0]    idx_reg;
    logic signed [15:0] res_reg [3];

    logic              out_valid_reg;
    hnm_pkg::out_word_t out_reg;

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic          accept, go_item;
    logic [AW-1:0] c_sel;
    logic          emit_sel, left_sel, right_sel, up_sel, last_sel;
    logic [15:0]   erow_sel;
    logic [AW-1:0] col_a;
    logic [15:0]   row_a;
    logic [AW-1:0] d_sel;

    logic          above_we, two_we;
    logic [AW-1:0] above_ra, two_ra;
    logic [7:0]    above_q, two_q;

    hnm_pkg::norm_req_t nreq;
    hnm_pkg::norm_rsp_t nrsp;

    logic [7:0]       l_v, r_v, u_v, d_v;
    logic signed [8:0] dx, dz;
    logic [7:0]       adx, adz;
    logic             out_load;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > hnm_pkg::MAX_WIDTH)
        begin
            w_eff = WW'(hnm_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg == '0) ? 16'd1 : height_reg;
    end

    // counter update and neighbour availability for the word being accepted
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        go_item    = 1'b0;
        c_sel      = col_reg;
        emit_sel   = 1'b0;
        left_sel   = 1'b0;
        right_sel  = 1'b0;
        up_sel     = 1'b0;
        last_sel   = 1'b0;
        erow_sel   = '0;
        col_a      = col_reg;
        row_a      = row_reg;
        d_sel      = drain_reg;
        if (in_data.req_type == hnm_pkg::REQ_SAMPLE)
        begin
            if (row_reg < h_eff && WW'(col_reg) >= w_eff)
            begin
                col_a = '0;
                row_a = 16'(row_reg + 16'd1);
            end
            col_next = col_a;
            row_next = row_a;
            if (row_a < h_eff)
            begin
                go_item   = 1'b1;
                c_sel     = col_a;
                emit_sel  = (row_a != '0);
                left_sel  = (col_a != '0);
                right_sel = (WW'(col_a) + WW'(1)) < w_eff;
                up_sel    = (row_a >= 16'd2);
                erow_sel  = 16'(row_a - 16'd1);
                if ((WW'(col_a) + WW'(1)) >= w_eff)
                begin
                    col_next = '0;
                    row_next = 16'(row_a + 16'd1);
                end
                else
                begin
                    col_next = AW'(col_a + 1'b1);
                end
            end
        end
        else if (row_reg >= h_eff)
        begin
            d_sel     = (WW'(drain_reg) >= w_eff) ? AW'(w_eff - WW'(1)) : drain_reg;
            go_item   = 1'b1;
            c_sel     = d_sel;
            emit_sel  = 1'b1;
            left_sel  = (d_sel != '0);
            right_sel = (WW'(d_sel) + WW'(1)) < w_eff;
            up_sel    = (row_reg >= 16'd2);
            erow_sel  = 16'(row_reg - 16'd1);
            last_sel  = (WW'(d_sel) + WW'(1)) >= w_eff;
            if (last_sel)
            begin
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
            end
            else
            begin
                drain_next = AW'(d_sel + 1'b1);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hnm_pkg::ST_IDLE:
            begin
                if (accept && go_item)
                begin
                    state_next = hnm_pkg::ST_RD0;
                end
            end
            hnm_pkg::ST_RD0:    state_next = hnm_pkg::ST_RD1;
            hnm_pkg::ST_RD1:    state_next = hnm_pkg::ST_RD2;
            hnm_pkg::ST_RD2:    state_next = emit_reg ? hnm_pkg::ST_MUL : hnm_pkg::ST_IDLE;
            hnm_pkg::ST_MUL:    state_next = hnm_pkg::ST_SQ;
            hnm_pkg::ST_SQ:
            begin
                if (idx_reg == 2'd2)
                begin
                    state_next = hnm_pkg::ST_SUM;
                end
            end
            hnm_pkg::ST_SUM:    state_next = hnm_pkg::ST_NSTART;
            hnm_pkg::ST_NSTART: state_next = hnm_pkg::ST_NWAIT;
            hnm_pkg::ST_NWAIT:
            begin
                if (nrsp.done)
                begin
                    state_next = (idx_reg == 2'd2) ? hnm_pkg::ST_OUT : hnm_pkg::ST_NSTART;
                end
            end
            hnm_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = hnm_pkg::ST_IDLE;
                end
            end
            default:            state_next = hnm_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall   = 1'b1;
        above_we   = 1'b0;
        two_we     = 1'b0;
        above_ra   = pos_reg;
        two_ra     = pos_reg;
        nreq.start = 1'b0;
        nreq.neg   = neg_reg[idx_reg];
        nreq.sum   = sum_reg;
        nreq.msq   = sq_reg[idx_reg];
        out_load   = 1'b0;
        case (state_reg)
            hnm_pkg::ST_IDLE:   in_stall = 1'b0;
            hnm_pkg::ST_RD0:
            begin
                above_ra = pos_reg;
                two_ra   = AW'(pos_reg - 1'b1);
            end
            hnm_pkg::ST_RD1:
            begin
                above_ra = AW'(pos_reg + 1'b1);
                two_ra   = pos_reg;
            end
            hnm_pkg::ST_RD2:
            begin
                two_we   = 1'b1;
                above_we = !drain_item_reg;
            end
            hnm_pkg::ST_NSTART: nreq.start = 1'b1;
            hnm_pkg::ST_OUT:    out_load = !out_valid_reg || !out_stall;
            default:            in_stall = 1'b1;
        endcase
    end

    assign l_v = left_ok_reg ? left_reg : ctr_reg;
    assign r_v = right_ok_reg ? right_reg : ctr_reg;
    assign u_v = up_ok_reg ? up_reg : ctr_reg;
    assign d_v = drain_item_reg ? ctr_reg : sample_reg;
    assign dx  = $signed({1'b0, l_v}) - $signed({1'b0, r_v});
    assign dz  = $signed({1'b0, u_v}) - $signed({1'b0, d_v});
    assign adx = dx[8] ? 8'(-dx) : dx[7:0];
    assign adz = dz[8] ? 8'(-dz) : dz[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hnm_pkg::ST_IDLE;
            width_reg     <= 12'd256;
            height_reg    <= 16'd256;
            scale_reg     <= 16'd256;
            spacing_reg   <= 16'd256;
            col_reg       <= '0;
            row_reg       <= '0;
            drain_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hnm_pkg::CFG_WIDTH:   width_reg   <= cfg_data[11:0];
                    hnm_pkg::CFG_HEIGHT:  height_reg  <= cfg_data;
                    hnm_pkg::CFG_SCALE:   scale_reg   <= cfg_data;
                    hnm_pkg::CFG_SPACING: spacing_reg <= cfg_data;
                    default:              spacing_reg <= spacing_reg;
                endcase
            end
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                drain_reg <= drain_next;
            end
            if (state_reg == hnm_pkg::ST_MUL || state_reg == hnm_pkg::ST_SUM)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == hnm_pkg::ST_SQ)
            begin
                idx_reg <= 2'(idx_reg + 1'b1);
            end
            else if (state_reg == hnm_pkg::ST_NWAIT && nrsp.done)
            begin
                idx_reg <= 2'(idx_reg + 1'b1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg        <= c_sel;
            erow_reg       <= erow_sel;
            drain_item_reg <= in_data.req_type;
            emit_reg       <= emit_sel;
            left_ok_reg    <= left_sel;
            right_ok_reg   <= right_sel;
            up_ok_reg      <= up_sel;
            last_reg       <= last_sel;
            sample_reg     <= in_data.height_sample;
        end
        if (state_reg == hnm_pkg::ST_RD1)
        begin
            ctr_reg  <= above_q;
            left_reg <= two_q;
        end
        if (state_reg == hnm_pkg::ST_RD2)
        begin
            right_reg <= above_q;
            up_reg    <= two_q;
        end
        if (state_reg == hnm_pkg::ST_MUL)
        begin
            mag_reg[0] <= hnm_pkg::MAG_W'(adx) * hnm_pkg::MAG_W'(scale_reg);
            mag_reg[1] <= hnm_pkg::MAG_W'({spacing_reg, 1'b0});
            mag_reg[2] <= hnm_pkg::MAG_W'(adz) * hnm_pkg::MAG_W'(scale_reg);
            neg_reg[0] <= dx[8];
            neg_reg[1] <= 1'b0;
            neg_reg[2] <= dz[8];
        end
        if (state_reg == hnm_pkg::ST_SQ)
        begin
            sq_reg[idx_reg] <= mag_reg[idx_reg] * mag_reg[idx_reg];
        end
        if (state_reg == hnm_pkg::ST_SUM)
        begin
            sum_reg <= hnm_pkg::SUM_W'(sq_reg[0]) + hnm_pkg::SUM_W'(sq_reg[1])
                     + hnm_pkg::SUM_W'(sq_reg[2]);
        end
        if (state_reg == hnm_pkg::ST_NWAIT && nrsp.done)
        begin
            res_reg[idx_reg] <= nrsp.value;
        end
        if (out_load)
        begin
            out_reg.normal_x  <= res_reg[0];
            out_reg.normal_y  <= res_reg[1];
            out_reg.normal_z  <= res_reg[2];
            out_reg.pixel_col <= 11'(pos_reg);
            out_reg.pixel_row <= erow_reg;
            out_reg.frame_end <= last_reg;
        end
    end

    // row above: written with the new sample
    hnm_ram #(
        .WIDTH (8),
        .DEPTH (hnm_pkg::MAX_WIDTH)
    ) u_above (
        .clk   (clk),
        .we    (above_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (above_ra),
        .rdata (above_q)
    );

    // row two up: takes over the old row above entry
    hnm_ram #(
        .WIDTH (8),
        .DEPTH (hnm_pkg::MAX_WIDTH)
    ) u_two_up (
        .clk   (clk),
        .we    (two_we),
        .waddr (pos_reg),
        .wdata (ctr_reg),
        .raddr (two_ra),
        .rdata (two_q)
    );

    hnm_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .rsp   (nrsp)
    );

endmodule

>>> test/heightmap_normal_generator_tb.sv
// self-checking testbench of the heightmap normal generator with its own normal predictor
module heightmap_normal_generator_tb;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    hnm_pkg::in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    hnm_pkg::out_word_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    heightmap_normal_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    hnm_pkg::in_word_t  pending_words[$];
    hnm_pkg::out_word_t expected_normals[$];
    bit        failed = 1'b0;
    int        words_taken = 0;
    int        send_idle_pct = 7;
    int        recv_idle_pct = 61;
    int        quiet_cycles = 0;

    // predictor copy of the block state and registers
    logic [7:0]  line_above[hnm_pkg::MAX_WIDTH];
    logic [7:0]  line_two_up[hnm_pkg::MAX_WIDTH];
    int unsigned col_cnt = 0, row_cnt = 0, drain_cnt = 0;
    int unsigned reg_width = 256, reg_height = 256, reg_scale = 256, reg_spacing = 256;

    function automatic logic [15:0] unit_component(longint v, logic [127:0] s);
        logic [127:0] mag, rhs, t;
        longint unsigned lo, hi, mid;
        mag = (v < 0) ? -v : v;
        rhs = (mag * mag) << (2 * hnm_pkg::OUT_FRAC_BITS + 2);
        lo = 0;
        hi = (64'd1 << hnm_pkg::OUT_FRAC_BITS) + 1;
        if (s == 0 || mag == 0)
            return 16'd0;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            t = 2 * mid - 1;
            if (t * t * s <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (v < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic void push_normal(int unsigned c, int unsigned r, int l, int rt,
                                        int up, int dn, bit last);
        longint x, y, z;
        logic [127:0] s;
        hnm_pkg::out_word_t o;
        x = longint'(l - rt) * reg_scale;
        y = 2 * longint'(reg_spacing);
        z = longint'(up - dn) * reg_scale;
        s = x * x + y * y + z * z;
        o.normal_x = unit_component(x, s);
        o.normal_y = unit_component(y, s);
        o.normal_z = unit_component(z, s);
        o.pixel_col = c[10:0];
        o.pixel_row = r[15:0];
        o.frame_end = last;
        expected_normals.push_back(o);
    endfunction

    function automatic void predict_word(hnm_pkg::in_word_t w);
        int unsigned wd, ht, c, r, d, ctr, l, rt, up;
        wd = (reg_width == 0) ? 1 :
             ((reg_width > hnm_pkg::MAX_WIDTH) ? hnm_pkg::MAX_WIDTH : reg_width);
        ht = (reg_height == 0) ? 1 : reg_height;
        if (w.req_type == hnm_pkg::REQ_SAMPLE)
        begin
            if (row_cnt < ht && col_cnt >= wd)
            begin
                col_cnt = 0;
                row_cnt++;
            end
            if (row_cnt >= ht)
                return;
            c = col_cnt;
            r = row_cnt;
            if (r >= 1)
            begin
                ctr = line_above[c];
                l = (c > 0) ? line_two_up[c - 1] : ctr;
                rt = (c + 1 < wd) ? line_above[c + 1] : ctr;
                up = (r >= 2) ? line_two_up[c] : ctr;
                push_normal(c, r - 1, l, rt, up, w.height_sample, 1'b0);
            end
            line_two_up[c] = line_above[c];
            line_above[c] = w.height_sample;
            if (c + 1 >= wd)
            begin
                col_cnt = 0;
                row_cnt++;
            end
            else
                col_cnt = c + 1;
            return;
        end
        if (row_cnt < ht)
            return;
        d = (drain_cnt >= wd) ? wd - 1 : drain_cnt;
        r = row_cnt - 1;
        ctr = line_above[d];
        l = (d > 0) ? line_two_up[d - 1] : ctr;
        rt = (d + 1 < wd) ? line_above[d + 1] : ctr;
        up = (r >= 1) ? line_two_up[d] : ctr;
        push_normal(d, r, l, rt, up, ctr, d + 1 >= wd);
        line_two_up[d] = line_above[d];
        if (d + 1 >= wd)
        begin
            col_cnt = 0;
            row_cnt = 0;
            drain_cnt = 0;
        end
        else
            drain_cnt = d + 1;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_word(in_data);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        hnm_pkg::out_word_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_normals.size() == 0)
                begin
                    $error("unexpected word: %p", out_data);
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_normals.pop_front();
                    if (out_data.normal_x !== e.normal_x)
                    begin
                        $error("normal_x expected %0d got %0d", e.normal_x, out_data.normal_x);
                        failed = 1'b1;
                    end
                    if (out_data.normal_y !== e.normal_y)
                    begin
                        $error("normal_y expected %0d got %0d", e.normal_y, out_data.normal_y);
                        failed = 1'b1;
                    end
                    if (out_data.normal_z !== e.normal_z)
                    begin
                        $error("normal_z expected %0d got %0d", e.normal_z, out_data.normal_z);
                        failed = 1'b1;
                    end
                    if (out_data.pixel_col !== e.pixel_col)
                    begin
                        $error("pixel_col expected %0d got %0d", e.pixel_col, out_data.pixel_col);
                        failed = 1'b1;
                    end
                    if (out_data.pixel_row !== e.pixel_row)
                    begin
                        $error("pixel_row expected %0d got %0d", e.pixel_row, out_data.pixel_row);
                        failed = 1'b1;
                    end
                    if (out_data.frame_end !== e.frame_end)
                    begin
                        $error("frame_end expected %0d got %0d", e.frame_end, out_data.frame_end);
                        failed = 1'b1;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // idling pattern follows progress
    always @(posedge clk)
    begin
        if (words_taken >= 1000)
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
        else if (words_taken >= 500)
        begin
            send_idle_pct <= 61;
            recv_idle_pct <= 7;
        end
    end

    task automatic write_reg(hnm_pkg::cfg_idx_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hnm_pkg::CFG_WIDTH:   reg_width = value[11:0];
            hnm_pkg::CFG_HEIGHT:  reg_height = value;
            hnm_pkg::CFG_SCALE:   reg_scale = value;
            hnm_pkg::CFG_SPACING: reg_spacing = value;
            default:              reg_spacing = reg_spacing;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_words.size() > 0 || in_valid || expected_normals.size() > 0);
        repeat (70) @(posedge clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h, int unsigned sc, int unsigned sp);
        write_reg(hnm_pkg::CFG_WIDTH, 16'(w));
        write_reg(hnm_pkg::CFG_HEIGHT, 16'(h));
        write_reg(hnm_pkg::CFG_SCALE, 16'(sc));
        write_reg(hnm_pkg::CFG_SPACING, 16'(sp));
    endtask

    function automatic logic [7:0] pick_height(int style, logic [7:0] prev);
        case (style)
            0: return 8'($urandom);
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            2: return prev;
            default: return 8'(prev + $urandom_range(6) - 3);
        endcase
    endfunction

    // rows of samples, then the drain once the frame is complete, with optional ignored noise words
    task automatic queue_frame(int unsigned w, int unsigned h, int unsigned rows, bit noise);
        hnm_pkg::in_word_t iw;
        logic [7:0] prev;
        int style;
        prev = 8'($urandom);
        style = $urandom_range(3);
        for (int unsigned i = 0; i < w * rows; i++)
        begin
            if (noise && $urandom_range(19) == 0)
            begin
                iw.req_type = hnm_pkg::REQ_DRAIN;
                iw.height_sample = 8'($urandom);
                pending_words.push_back(iw);
            end
            prev = pick_height(style, prev);
            iw.req_type = hnm_pkg::REQ_SAMPLE;
            iw.height_sample = prev;
            pending_words.push_back(iw);
        end
        if (rows < h)
            return;
        for (int unsigned i = 0; i < w; i++)
        begin
            if (noise && $urandom_range(9) == 0)
            begin
                iw.req_type = hnm_pkg::REQ_SAMPLE;
                iw.height_sample = 8'($urandom);
                pending_words.push_back(iw);
            end
            iw.req_type = hnm_pkg::REQ_DRAIN;
            iw.height_sample = 8'($urandom);
            pending_words.push_back(iw);
        end
    endtask

    initial
    begin
        int unsigned w, h, sc, sp;
        hnm_pkg::in_word_t iw;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // steep edges, drain before the first row, sample after the last
        set_size(3, 3, 16'hFFFF, 1);
        iw.req_type = hnm_pkg::REQ_DRAIN;
        iw.height_sample = 8'hFF;
        pending_words.push_back(iw);
        for (int i = 0; i < 9; i++)
        begin
            iw.req_type = hnm_pkg::REQ_SAMPLE;
            iw.height_sample = (i % 2) ? 8'hFF : 8'h00;
            pending_words.push_back(iw);
        end
        iw.req_type = hnm_pkg::REQ_SAMPLE;
        iw.height_sample = 8'hAA;
        pending_words.push_back(iw);
        for (int i = 0; i < 3; i++)
        begin
            iw.req_type = hnm_pkg::REQ_DRAIN;
            iw.height_sample = 8'h55;
            pending_words.push_back(iw);
        end
        wait_idle();

        // zero sizes behave as one, zero length vector
        set_size(0, 0, 0, 0);
        queue_frame(1, 1, 1, 1'b0);
        wait_idle();
        write_reg(hnm_pkg::CFG_SPACING, 16'hFFFF);
        queue_frame(1, 1, 1, 1'b0);
        wait_idle();

        // tall frame cut short by lowering the height
        set_size(4, 16'hFFFF, 300, 128);
        queue_frame(4, 16'hFFFF, 3, 1'b0);
        wait_idle();
        write_reg(hnm_pkg::CFG_HEIGHT, 16'd2);
        queue_frame(4, 2, 0, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            iw.req_type = hnm_pkg::REQ_DRAIN;
            iw.height_sample = 8'($urandom);
            pending_words.push_back(iw);
        end
        wait_idle();

        while (words_taken < 1250)
        begin
            w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            case ($urandom_range(3))
                0: sc = 16'hFFFF;
                1: sc = $urandom_range(1);
                default: sc = $urandom_range(16'hFFFF);
            endcase
            case ($urandom_range(3))
                0: sp = 16'hFFFF;
                1: sp = 1;
                default: sp = $urandom_range(16'hFFFF, 1);
            endcase
            set_size(w, h, sc, sp);
            repeat ($urandom_range(3, 1))
                queue_frame(w, h, h, $urandom_range(1));
            wait_idle();
        end

        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/hnm_pkg.sv
hdl/hnm_ram.sv
hdl/hnm_norm.sv
hdl/heightmap_normal_generator.sv
test/heightmap_normal_generator_tb.sv
